// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the servo RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/cps_pkg.sv =====
// Package for the clock phase servo: opcodes, states, command struct, constants.
// No dependencies.
`default_nettype none
package cps_pkg;
  localparam logic [31:0] PeriodReset = 32'd100000000;
  localparam int          DivSteps    = 64;
  // x / 100 for 32-bit x as (x * Div100Mul) >> Div100Shift
  localparam logic [31:0] Div100Mul   = 32'h51EB851F;
  localparam int          Div100Shift = 37;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CTRL  = 2'd1,
    OP_RST_I = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TDIV, ST_TFIN, ST_CDIV, ST_CMUL, ST_CMUH, ST_CERR, ST_CINT, ST_CLMP,
    ST_MISC, ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture beat, start divider
    logic div_step;   // one restoring step
    logic tick_fin;
    logic ctl_mul;    // low word of ns per tick
    logic ctl_mul_hi; // high word of ns per tick
    logic ctl_err;
    logic ctl_int;
    logic ctl_clamp;
    logic misc;
    logic out_load;
  } cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cps_if.sv =====
// Valid/ready channel interfaces for the servo.
// Depends on nothing.
`default_nettype none
interface cps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] system_time_ns;
  logic [31:0] previous_period_ticks;
  logic [31:0] ticks_at_event;
  modport source (output valid, opcode, system_time_ns, previous_period_ticks,
                  ticks_at_event, input ready);
  modport sink (input valid, opcode, system_time_ns, previous_period_ticks,
                ticks_at_event, output ready);
endinterface

interface cps_out_if;
  logic               valid;
  logic               ready;
  logic signed [26:0] correction;
  logic [63:0]        next_wrap_ns;
  logic [32:0]        delay_to_trigger_ns;
  modport source (output valid, correction, next_wrap_ns, delay_to_trigger_ns,
                  input ready);
  modport sink (input valid, correction, next_wrap_ns, delay_to_trigger_ns,
                output ready);
endinterface

interface cps_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/clock_phase_pi_servo_unit.sv =====
// Clock phase PI servo: top level, output register and config register.
// Depends on cps_pkg, cps_if, cps_ctrl, cps_dp, assert_macros.svh.
//
// Usage: one input beat on in_ch (opcode 0 tick, 1 control, 2 reset
// integrator, 3 no-op) gives exactly one result beat on out_ch. The user must write
// period_ns through cfg_ch while the block is idle; the block does not enforce
// this. Reset value is 100000000 ns. Each item latches the period when accepted.
// A tick beat runs the 64-step restoring divider, then a finish step. The
// divider is shared by the modulo (tick) and the ns-per-tick quotient
// (control); a control beat then adds two multiply steps, error, integrate
// and clamp. Reset-integrator and no-op beats take one misc step. in_ch.ready
// is high only while idle, from the cycle after the result is loaded, so no
// new beat is accepted until the last result is in the output register.
// The result sits in an output register until taken. While the receiver
// stalls, the next item is still accepted and computed, then held until the
// output register frees; no further beat is accepted meanwhile.
// Synchronous reset clears the reference phase, next timestamp and integral,
// restores the period register to 100000000 and drops out_ch.valid.
`default_nettype none
module clock_phase_pi_servo_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cps_in_if.sink     in_ch,
  cps_out_if.source  out_ch,
  cps_cfg_if.sink    cfg_ch
);
  `include "assert_macros.svh"
  logic [31:0] period_r;
  logic        oval_r;
  cps_pkg::cmd_t cmd;
  logic in_rdy, out_free, in_fire;
  logic signed [26:0] r_corr;
  logic [63:0] r_next;
  logic [32:0] r_delay;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= cps_pkg::PeriodReset;
    else if (cfg_ch.valid) period_r <= cfg_ch.data;
  end

  assign in_ch.ready = in_rdy;
  assign in_fire  = in_ch.valid && in_rdy;
  assign out_free = !oval_r || out_ch.ready;

  cps_ctrl u_ctrl (.clk, .rst_n, .in_fire, .in_op(in_ch.opcode), .out_free,
                   .cmd, .in_rdy);
  cps_dp u_dp (.clk, .rst_n, .cmd, .period(period_r), .in_op(in_ch.opcode),
               .in_time(in_ch.system_time_ns), .in_old(in_ch.previous_period_ticks),
               .in_ticks(in_ch.ticks_at_event), .res_corr_r(r_corr),
               .res_next_r(r_next), .res_delay_r(r_delay));

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) oval_r <= 1'b0;
    else if (cmd.out_load) oval_r <= 1'b1;
    else if (out_ch.ready) oval_r <= 1'b0;
    if (cmd.out_load) begin
      out_ch.correction          <= r_corr;
      out_ch.next_wrap_ns        <= r_next;
      out_ch.delay_to_trigger_ns <= r_delay;
    end
  end
  assign out_ch.valid = oval_r;

  `ASSERT_NEXT(a_load_valid, clk, rst_n, cmd.out_load, oval_r)
  `ASSERT_IMPL(a_no_in_busy, clk, rst_n, in_fire, !cmd.out_load)
endmodule
`default_nettype wire

// ===== hw/rtl/cps_ctrl.sv =====
// Controller FSM for the servo: sequences divider, arithmetic steps, output.
// Depends on cps_pkg, assert_macros.svh.
`default_nettype none
module cps_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic [1:0]     in_op,
  input  wire logic           out_free,   // output register empty or being taken
  output cps_pkg::cmd_t       cmd,
  output logic                in_rdy
);
  `include "assert_macros.svh"
  cps_pkg::state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cps_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_rdy    = 1'b0;
    unique case (state_r)
      cps_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          unique case (in_op)
            cps_pkg::OP_TICK: state_nxt = cps_pkg::ST_TDIV;
            cps_pkg::OP_CTRL: state_nxt = cps_pkg::ST_CDIV;
            default:          state_nxt = cps_pkg::ST_MISC;
          endcase
        end
      end
      cps_pkg::ST_TDIV, cps_pkg::ST_CDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(cps_pkg::DivSteps - 1))
          state_nxt = (state_r == cps_pkg::ST_TDIV) ? cps_pkg::ST_TFIN
                                                    : cps_pkg::ST_CMUL;
      end
      cps_pkg::ST_TFIN: begin cmd.tick_fin = 1'b1; state_nxt = cps_pkg::ST_OUT; end
      cps_pkg::ST_CMUL: begin cmd.ctl_mul = 1'b1; state_nxt = cps_pkg::ST_CMUH; end
      cps_pkg::ST_CMUH: begin cmd.ctl_mul_hi = 1'b1; state_nxt = cps_pkg::ST_CERR; end
      cps_pkg::ST_CERR: begin cmd.ctl_err = 1'b1; state_nxt = cps_pkg::ST_CINT; end
      cps_pkg::ST_CINT: begin cmd.ctl_int = 1'b1; state_nxt = cps_pkg::ST_CLMP; end
      cps_pkg::ST_CLMP: begin cmd.ctl_clamp = 1'b1; state_nxt = cps_pkg::ST_OUT; end
      cps_pkg::ST_MISC: begin cmd.misc = 1'b1; state_nxt = cps_pkg::ST_OUT; end
      cps_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cps_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_rdy_idle, clk, rst_n, in_rdy, state_r == cps_pkg::ST_IDLE)
  `ASSERT_NEXT(a_fire_leaves, clk, rst_n, in_fire, state_r != cps_pkg::ST_IDLE)
  `ASSERT_IMPL(a_outload_free, clk, rst_n, cmd.out_load, out_free)
endmodule
`default_nettype wire

// ===== hw/rtl/cps_dp.sv =====
// Datapath for the servo: restoring divider, Q32 multiply, integrator, clamp.
// Depends on cps_pkg.
`default_nettype none
module cps_dp (
  input  wire logic               clk,
  input  wire cps_pkg::cmd_t      cmd,
  input  wire logic [31:0]        period,
  input  wire logic [1:0]         in_op,
  input  wire logic [63:0]        in_time,
  input  wire logic [31:0]        in_old,
  input  wire logic [31:0]        in_ticks,
  output logic signed [26:0]      res_corr_r,
  output logic [63:0]             res_next_r,
  output logic [32:0]             res_delay_r,
  input  wire logic               rst_n
);
  logic [1:0]  op_r;
  logic [63:0] time_r;
  logic [31:0] old_r, ticks_r, per_r;
  // divider: quotient/dividend shift register, remainder, divisor
  logic [63:0] q_r;
  logic [63:0] rem_r;
  logic [63:0] dvs_r;
  logic [63:0] phase_r, refph_r, snext_r, integ_r;
  logic signed [63:0] err_r;
  logic signed [64:0] corr_r;
  logic [32:0] lim_r;
  logic [64:0] trial;
  logic [64:0] rem_sh;

  // restoring divide step
  always_comb begin
    rem_sh = {rem_r, q_r[63]};
    trial  = rem_sh - {1'b0, dvs_r};
  end

  logic [63:0] rem64, p64, half;
  assign rem64 = rem_r;
  assign p64   = {32'd0, per_r};
  assign half  = {33'd0, per_r[31:1]};

  // one 32x32 multiplier: low word of ns per tick, then high word
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  assign mul_b = cmd.ctl_mul ? q_r[31:0] : q_r[63:32];
  assign mul_p = 64'(ticks_r) * 64'(mul_b);

  // old period / 100 by reciprocal multiply
  logic [63:0] lim_prod;
  assign lim_prod = 64'(old_r) * 64'(cps_pkg::Div100Mul);

  logic [63:0] ph_adj, diff;
  logic [63:0] integ_nxt;
  assign ph_adj = (phase_r > {1'b0, per_r, 31'd0}) ? phase_r - {per_r, 32'd0} : phase_r;
  assign diff   = ph_adj - refph_r;
  assign integ_nxt = integ_r + err_r;

  // both terms truncate toward zero
  logic signed [63:0] integ_s, e32, i512;
  assign integ_s = integ_nxt;
  assign e32  = err_r / 64'sd32;
  assign i512 = integ_s / 64'sd512;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refph_r <= '0;
      snext_r <= '0;
      integ_r <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= in_op; time_r <= in_time; old_r <= in_old; ticks_r <= in_ticks;
        per_r <= period;
        rem_r <= '0;
        if (in_op == cps_pkg::OP_TICK) begin
          q_r <= in_time; dvs_r <= {32'd0, period};
        end else begin
          q_r <= {period, 32'd0}; dvs_r <= {32'd0, in_old};
        end
      end
      if (cmd.div_step) begin
        if (!trial[64]) begin
          rem_r <= trial[63:0]; q_r <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh[63:0]; q_r <= {q_r[62:0], 1'b0};
        end
      end
      // tick finish; zero divisor leaves remainder equal to time, force 0
      if (cmd.tick_fin) begin
        if (per_r == 32'd0) begin
          refph_r <= '0; snext_r <= time_r;
          res_next_r <= time_r; res_delay_r <= '0;
        end else if (rem64 > half) begin
          refph_r <= {rem64[31:0] - per_r, 32'd0};
          snext_r <= time_r - rem64 + {p64[62:0], 1'b0};
          res_next_r <= time_r - rem64 + {p64[62:0], 1'b0};
          res_delay_r <= 33'({p64[62:0], 1'b0} - rem64);
        end else begin
          refph_r <= {rem64[31:0], 32'd0};
          snext_r <= time_r - rem64 + p64;
          res_next_r <= time_r - rem64 + p64;
          res_delay_r <= 33'(p64 - rem64);
        end
        res_corr_r <= '0;
      end
      // ticks times ns per tick, low 64 bits, over two steps
      if (cmd.ctl_mul)
        phase_r <= (old_r == 32'd0) ? 64'd0 : mul_p;
      if (cmd.ctl_mul_hi && old_r != 32'd0)
        phase_r <= phase_r + {mul_p[31:0], 32'd0};
      if (cmd.ctl_err) begin
        err_r <= {{32{diff[63]}}, diff[63:32]};
        lim_r <= 33'(lim_prod >> cps_pkg::Div100Shift);
      end
      if (cmd.ctl_int) begin
        integ_r <= integ_nxt;
        corr_r  <= 65'(e32) + 65'(i512);
      end
      if (cmd.ctl_clamp) begin
        if (corr_r > $signed({32'd0, lim_r}))
          res_corr_r <= 27'(lim_r);
        else if (corr_r < -$signed({32'd0, lim_r}))
          res_corr_r <= 27'(-$signed({32'd0, lim_r}));
        else
          res_corr_r <= 27'(corr_r);
        res_next_r <= snext_r; res_delay_r <= '0;
      end
      if (cmd.misc) begin
        if (op_r == cps_pkg::OP_RST_I) integ_r <= '0;
        res_corr_r <= '0; res_next_r <= snext_r; res_delay_r <= '0;
      end
    end
  end
endmodule
`default_nettype wire
